// ===== design/fxmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fxmd_pkg: shared types and constants of the Q16.16 multiply/divide unit
// Word widths, fraction size, operation codes and the record that moves
// along the divider cell chain.
// ----------------------------------------------------------------------------
package fxmd_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned FRAC_BITS     = 16;
	localparam int unsigned HEADROOM_BITS = 2;
	localparam int unsigned QUOT_BITS     = WORD_W - HEADROOM_BITS;
	localparam int unsigned NUM_W         = WORD_W + FRAC_BITS;
	localparam int unsigned CMP_W         = WORD_W + FRAC_BITS + HEADROOM_BITS;
	localparam int unsigned PROD_W        = 2 * WORD_W;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   cmd;
		logic                  neg;
		logic                  sat;
		logic [WORD_W-1:0]     rem;
		logic [WORD_W-1:0]     dvsr;
		logic [WORD_W-1:0]     acc;
		logic [QUOT_BITS-1:0]  low;
	} stage_t;

endpackage

// ===== design/fxmd_req_if.sv =====
// ----------------------------------------------------------------------------
// fxmd_req_if: request channel of the multiply/divide unit
// Carries one operation word with its opcode and two signed operands.
// ----------------------------------------------------------------------------
interface fxmd_req_if;

	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [fxmd_pkg::WORD_W-1:0]  operand_a;
	logic signed [fxmd_pkg::WORD_W-1:0]  operand_b;

	modport source (output valid, output cmd, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input cmd, input operand_a, input operand_b,
		output ready);

endinterface

// ===== design/fxmd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fxmd_rsp_if: response channel of the multiply/divide unit
// Carries one signed Q16.16 result word.
// ----------------------------------------------------------------------------
interface fxmd_rsp_if;

	logic                                valid;
	logic                                ready;
	logic signed [fxmd_pkg::WORD_W-1:0]  result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);

endinterface

// ===== design/fxmd_prep.sv =====
// ----------------------------------------------------------------------------
// fxmd_prep: operand preparation stage
// Forms the shifted product for multiply, and for divide the magnitudes,
// result sign, overflow flag and the initial partial remainder.
// ----------------------------------------------------------------------------
module fxmd_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic                                cmd,
	input  logic signed [fxmd_pkg::WORD_W-1:0]  operand_a,
	input  logic signed [fxmd_pkg::WORD_W-1:0]  operand_b,
	output logic                                valid_s1,
	output fxmd_pkg::stage_t                    data_s1
);

	logic [fxmd_pkg::WORD_W-1:0]        mag_a;
	logic [fxmd_pkg::WORD_W-1:0]        mag_b;
	logic [fxmd_pkg::NUM_W-1:0]         num;
	logic signed [fxmd_pkg::PROD_W-1:0] prod;
	fxmd_pkg::op_t                      op;
	fxmd_pkg::stage_t                   nxt;

	assign op = fxmd_pkg::op_t'(cmd);

	always_comb begin
		mag_a = operand_a[fxmd_pkg::WORD_W-1] ? (~operand_a + 1'b1) : operand_a;
		mag_b = operand_b[fxmd_pkg::WORD_W-1] ? (~operand_b + 1'b1) : operand_b;
		num   = {mag_a, {fxmd_pkg::FRAC_BITS{1'b0}}};
		prod  = $signed(operand_a) * $signed(operand_b);

		nxt.cmd  = op;
		nxt.neg  = operand_a[fxmd_pkg::WORD_W-1] ^ operand_b[fxmd_pkg::WORD_W-1];
		nxt.sat  = fxmd_pkg::CMP_W'({mag_a, {fxmd_pkg::HEADROOM_BITS{1'b0}}}) >=
			fxmd_pkg::CMP_W'({mag_b, {fxmd_pkg::FRAC_BITS{1'b0}}});
		nxt.rem  = fxmd_pkg::WORD_W'(num[fxmd_pkg::NUM_W-1:fxmd_pkg::QUOT_BITS]);
		nxt.low  = num[fxmd_pkg::QUOT_BITS-1:0];
		nxt.dvsr = mag_b;
		if (op == fxmd_pkg::OP_MUL) begin
			nxt.acc = prod[fxmd_pkg::FRAC_BITS+fxmd_pkg::WORD_W-1:fxmd_pkg::FRAC_BITS];
		end else begin
			nxt.acc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== design/fxmd_div_cell.sv =====
// ----------------------------------------------------------------------------
// fxmd_div_cell: one restoring division step
// Brings down the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit into the accumulator. Multiply words keep their accumulator unchanged.
// ----------------------------------------------------------------------------
module fxmd_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  fxmd_pkg::stage_t  in_data,
	output logic              valid_q,
	output fxmd_pkg::stage_t  data_q
);

	logic [fxmd_pkg::WORD_W:0] shifted;
	logic [fxmd_pkg::WORD_W:0] diff;
	logic                      take;
	fxmd_pkg::stage_t          nxt;

	always_comb begin
		shifted = {in_data.rem, in_data.low[fxmd_pkg::QUOT_BITS-1]};
		diff    = shifted - {1'b0, in_data.dvsr};
		take    = shifted >= {1'b0, in_data.dvsr};

		nxt     = in_data;
		nxt.rem = take ? diff[fxmd_pkg::WORD_W-1:0] : shifted[fxmd_pkg::WORD_W-1:0];
		nxt.low = in_data.low << 1;
		if (in_data.cmd == fxmd_pkg::OP_DIV) begin
			nxt.acc = {in_data.acc[fxmd_pkg::WORD_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== design/fixed_16_16_mul_div_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_16_16_mul_div_unit: signed Q16.16 multiply and divide
//
//   channel  role    word contents
//   req      sink    cmd (0 multiply, 1 divide), operand_a, operand_b
//   rsp      source  result
//
// A new word is taken every cycle while the chain advances. Each word passes
// through one preparation stage with the multiplier, a chain of 30 divider cells
// (one quotient bit each) and the output register.
// The whole chain advances together; it stops only while a result waits in
// the output register and rsp is not ready.
// Reset clears the valid bits of all stages; no other setup is needed.
// ----------------------------------------------------------------------------
module fixed_16_16_mul_div_unit (
	input  logic         clk,
	input  logic         arst_n,
	fxmd_req_if.sink     req,
	fxmd_rsp_if.source   rsp
);

	logic                            en;
	logic                            chain_valid [fxmd_pkg::QUOT_BITS+1];
	fxmd_pkg::stage_t                chain_data  [fxmd_pkg::QUOT_BITS+1];
	fxmd_pkg::stage_t                last;
	logic [fxmd_pkg::WORD_W-1:0]     final_word;
	logic                            rsp_valid_q;
	logic [fxmd_pkg::WORD_W-1:0]     result_q;

	assign en        = !rsp_valid_q || rsp.ready;
	assign req.ready = en;

	fxmd_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.cmd       (req.cmd),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.valid_s1  (chain_valid[0]),
		.data_s1   (chain_data[0])
	);

	for (genvar i = 0; i < fxmd_pkg::QUOT_BITS; i++) begin : g_cell
		fxmd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (chain_valid[i]),
			.in_data  (chain_data[i]),
			.valid_q  (chain_valid[i+1]),
			.data_q   (chain_data[i+1])
		);
	end

	assign last = chain_data[fxmd_pkg::QUOT_BITS];

	always_comb begin
		if (last.cmd == fxmd_pkg::OP_MUL) begin
			final_word = last.acc;
		end else if (last.sat) begin
			final_word = last.neg ? {1'b1, {(fxmd_pkg::WORD_W-1){1'b0}}}
				: {1'b0, {(fxmd_pkg::WORD_W-1){1'b1}}};
		end else if (last.neg) begin
			final_word = ~last.acc + 1'b1;
		end else begin
			final_word = last.acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= chain_valid[fxmd_pkg::QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= final_word;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = result_q;

endmodule

// ===== tb/sv/tb_fixed_16_16_mul_div_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_16_16_mul_div_unit: self-checking bench of the Q16.16 mul/div unit
// A driver sends directed and then random operation words, each with random
// idle bursts. A monitor predicts every accepted word's result, stalls the
// response channel at random, and compares each returned word in order.
// ----------------------------------------------------------------------------
module tb_fixed_16_16_mul_div_unit;

	localparam int unsigned                    RANDOM_WORDS = 1200;
	localparam int unsigned                    QUIET_TAIL   = 150;
	localparam int unsigned                    DRAIN_AT     = 600;
	localparam int unsigned                    SETTLE_CYC   = 40;
	localparam int unsigned                    STALL_LIMIT  = 2000;
	localparam int unsigned                    SHOWN_ERRORS = 10;
	localparam logic [fxmd_pkg::WORD_W-1:0]    SAT_NEG      = 32'h8000_0000;
	localparam logic [fxmd_pkg::WORD_W-1:0]    SAT_POS      = 32'h7FFF_FFFF;
	localparam logic [fxmd_pkg::WORD_W-1:0]    Q_ONE        = 32'h0001_0000;

	typedef struct packed {
		fxmd_pkg::op_t                       cmd;
		logic signed [fxmd_pkg::WORD_W-1:0]  a;
		logic signed [fxmd_pkg::WORD_W-1:0]  b;
	} mdu_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	fxmd_req_if req_ch ();
	fxmd_rsp_if rsp_ch ();

	fixed_16_16_mul_div_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mdu_word_t                    stim_q[$];
	logic [fxmd_pkg::WORD_W-1:0]  due_results[$];
	mdu_word_t                    next_word;
	int unsigned                  n_total;
	int unsigned                  words_sent;
	int unsigned                  words_in;
	int unsigned                  results_seen;
	int unsigned                  fail_count;
	int unsigned                  src_gap;
	int unsigned                  sink_gap;
	int unsigned                  src_idle_pct;
	int unsigned                  sink_idle_pct;
	int unsigned                  stall_cyc;
	logic                         drain_done;
	logic [fxmd_pkg::WORD_W-1:0]  want;

	function automatic logic [fxmd_pkg::WORD_W-1:0] q16_result(fxmd_pkg::op_t cmd,
			logic signed [fxmd_pkg::WORD_W-1:0] a, logic signed [fxmd_pkg::WORD_W-1:0] b);
		longint          sa;
		longint          sb;
		longint          prod;
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned quot;
		logic            neg;
		sa = a;
		sb = b;
		if (cmd == fxmd_pkg::OP_MUL) begin
			prod = (sa * sb) >>> fxmd_pkg::FRAC_BITS;
			return prod[fxmd_pkg::WORD_W-1:0];
		end
		ma = (sa < 0) ? -sa : sa;
		mb = (sb < 0) ? -sb : sb;
		neg = (sa < 0) != (sb < 0);
		if ((ma << fxmd_pkg::HEADROOM_BITS) >= (mb << fxmd_pkg::FRAC_BITS))
			return neg ? SAT_NEG : SAT_POS;
		quot = (ma << fxmd_pkg::FRAC_BITS) / mb;
		if (neg)
			quot = -quot;
		return quot[fxmd_pkg::WORD_W-1:0];
	endfunction

	function automatic logic signed [fxmd_pkg::WORD_W-1:0] rand_operand();
		logic signed [fxmd_pkg::WORD_W-1:0] v;
		v = $urandom();
		case ($urandom_range(0, 5))
			0, 1: return v;
			2: return v >>> $urandom_range(0, 31);
			3: return $signed(Q_ONE) + $signed(32'($urandom_range(0, 255))) - 128;
			4: begin
				case ($urandom_range(0, 6))
					0: return '0;
					1: return 32'sd1;
					2: return -32'sd1;
					3: return $signed(SAT_POS);
					4: return $signed(SAT_NEG);
					5: return $signed(Q_ONE);
					default: return -$signed(Q_ONE);
				endcase
			end
			default: return v >>> 14;
		endcase
	endfunction

	task automatic add_word(fxmd_pkg::op_t cmd, logic [fxmd_pkg::WORD_W-1:0] a,
			logic [fxmd_pkg::WORD_W-1:0] b);
		mdu_word_t w;
		w.cmd = cmd;
		w.a = a;
		w.b = b;
		stim_q.push_back(w);
	endtask

	task automatic report_error(string what, logic [fxmd_pkg::WORD_W-1:0] exp_v,
			logic [fxmd_pkg::WORD_W-1:0] act_v);
		fail_count++;
		if (fail_count <= SHOWN_ERRORS)
			$display("ERROR %0t: %s: expected %08h, got %08h", $time, what, exp_v, act_v);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		mdu_word_t w;
		logic signed [fxmd_pkg::WORD_W-1:0] a_s;
		fail_count = 0;
		add_word(fxmd_pkg::OP_MUL, 32'h0000_0000, 32'h0000_0000);
		add_word(fxmd_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_word(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		add_word(fxmd_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
		add_word(fxmd_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);
		add_word(fxmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(fxmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
		add_word(fxmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0001_0000);
		add_word(fxmd_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h0001_0000);
		add_word(fxmd_pkg::OP_MUL, 32'h1234_5678, 32'hFFFF_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h0000_0005, 32'h0000_0000);
		add_word(fxmd_pkg::OP_DIV, 32'hFFFF_FFFB, 32'h0000_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF);
		add_word(fxmd_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
		add_word(fxmd_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_word(fxmd_pkg::OP_DIV, 32'h4000_0000, 32'h0001_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h3FFF_FFFF, 32'h0001_0000);
		add_word(fxmd_pkg::OP_DIV, 32'hC000_0000, 32'h0001_0000);
		add_word(fxmd_pkg::OP_DIV, 32'h0000_0001, 32'h7FFF_FFFF);
		add_word(fxmd_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0003);
		add_word(fxmd_pkg::OP_DIV, 32'h0000_0007, 32'hFFFF_FFFF);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			w.cmd = fxmd_pkg::op_t'($urandom_range(0, 1));
			w.a = rand_operand();
			if (w.cmd == fxmd_pkg::OP_DIV && $urandom_range(0, 3) == 0) begin
				// Divisors right at the saturation threshold of the dividend.
				a_s = w.a;
				w.b = (a_s >>> (fxmd_pkg::FRAC_BITS - fxmd_pkg::HEADROOM_BITS))
					+ int'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1) == 1)
					w.b = -w.b;
			end else begin
				w.b = rand_operand();
			end
			stim_q.push_back(w);
		end
		n_total = stim_q.size();
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (!(words_in == n_total && due_results.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("tb_fixed_16_16_mul_div_unit passed");
		end else begin
			$display("tb_fixed_16_16_mul_div_unit failed");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= fxmd_pkg::OP_MUL;
			req_ch.operand_a <= '0;
			req_ch.operand_b <= '0;
			words_sent = 0;
			src_gap = 0;
			src_idle_pct = 0;
			drain_done = 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				words_sent++;
			if (!req_ch.valid || req_ch.ready) begin
				if (!drain_done && words_sent == DRAIN_AT) begin
					// Hold the request side until every pending word has returned.
					req_ch.valid <= 1'b0;
					if (results_seen == words_sent)
						drain_done = 1'b1;
				end else if (src_gap > 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (stim_q.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else begin
					next_word = stim_q.pop_front();
					req_ch.cmd <= next_word.cmd;
					req_ch.operand_a <= next_word.a;
					req_ch.operand_b <= next_word.b;
					req_ch.valid <= 1'b1;
					if (words_sent % 100 == 0) begin
						case ($urandom_range(0, 2))
							0: src_idle_pct = 0;
							1: src_idle_pct = 8;
							default: src_idle_pct = 25;
						endcase
					end
					if (words_sent + QUIET_TAIL < n_total && $urandom_range(0, 99) < src_idle_pct)
						src_gap = $urandom_range(1, 11);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			words_in = 0;
			results_seen = 0;
			sink_gap = 0;
			sink_idle_pct = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(q16_result(fxmd_pkg::op_t'(req_ch.cmd), req_ch.operand_a,
					req_ch.operand_b));
				words_in++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					report_error("result word with none pending", 'x, rsp_ch.result);
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.result !== want)
						report_error("result mismatch", want, rsp_ch.result);
				end
				if (results_seen % 100 == 0) begin
					case ($urandom_range(0, 2))
						0: sink_idle_pct = 0;
						1: sink_idle_pct = 10;
						default: sink_idle_pct = 30;
					endcase
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (words_in + QUIET_TAIL < n_total && $urandom_range(0, 99) < sink_idle_pct)
					sink_gap = $urandom_range(1, 11);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cyc = 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cyc = 0;
			end else begin
				stall_cyc++;
				if (stall_cyc >= STALL_LIMIT) begin
					$display("tb_fixed_16_16_mul_div_unit failed");
					$finish;
				end
			end
		end
	end

endmodule
